// ===== rtl/space_vector_pwm_modulator_defines.svh =====
// Assertion macros for the space vector PWM modulator port checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef SPACE_VECTOR_PWM_MODULATOR_DEFINES_SVH
`define SPACE_VECTOR_PWM_MODULATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define SVPWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svpwm port check failed");

// Next-cycle implication, checked out of reset only
`define SVPWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svpwm port check failed");

`endif

// ===== rtl/svpwm_pkg.sv =====
// Shared types, constants and tables of the space vector PWM modulator.
// No dependencies; used by all cells and the top level.
`default_nettype none

package svpwm_pkg;

  // Datapath widths
  localparam int unsigned VecXyW  = 40;  // vectoring x/y: 17 bit input << 20 plus growth
  localparam int unsigned RotXyW  = 34;  // rotation x/y in Q30 plus growth
  localparam int unsigned CordicZw = 34; // angle accumulator, 2^32 per turn plus guard

  // Fixed-point constants
  localparam logic [31:0]            TurnHalf = 32'h8000_0000;
  localparam logic signed [RotXyW-1:0] CordicK = 34'sd652032875;
  localparam logic [30:0]            Sqrt3Q30 = 31'd1859775393;
  localparam logic [30:0]            OneQ30   = 31'h4000_0000;
  localparam logic [24:0]            RatioMax = 25'h100_0000;

  typedef enum logic [0:0] {
    CORDIC_VECTOR,
    CORDIC_ROTATE
  } cordic_mode_e;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_e;

  // Payload carried beside the vectoring CORDIC
  typedef struct packed {
    logic [31:0] sq;
    logic [31:0] ang;
    logic        zero;
  } vec_side_t;

  // Payload carried beside the root and divider cells
  typedef struct packed {
    logic [29:0] arg_hi;
    logic [29:0] arg_lo;
    sector_e     sector;
  } root_side_t;

  // One finished result
  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    sector_e     sector;
  } result_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] res;
    case (idx)
      0:       res = 32'h2000_0000;
      1:       res = 32'h12E4_051E;
      2:       res = 32'h09FB_385B;
      3:       res = 32'h0511_11D4;
      4:       res = 32'h028B_0D43;
      5:       res = 32'h0145_D7E1;
      6:       res = 32'h00A2_F61E;
      7:       res = 32'h0051_7C55;
      8:       res = 32'h0028_BE53;
      9:       res = 32'h0014_5F2F;
      10:      res = 32'h000A_2F98;
      11:      res = 32'h0005_17CC;
      12:      res = 32'h0002_8BE6;
      13:      res = 32'h0001_45F3;
      14:      res = 32'h0000_A2FA;
      15:      res = 32'h0000_517D;
      16:      res = 32'h0000_28BE;
      17:      res = 32'h0000_145F;
      18:      res = 32'h0000_0A30;
      19:      res = 32'h0000_0518;
      20:      res = 32'h0000_028C;
      21:      res = 32'h0000_0146;
      22:      res = 32'h0000_00A3;
      23:      res = 32'h0000_0051;
      default: res = 32'h0000_0000;
    endcase
    return res;
  endfunction

  // ceil(s * 2^32 / 6): start of sector s in turn units
  function automatic logic [32:0] sector_start(input sector_e s);
    logic [32:0] res;
    case (s)
      SECTOR_0: res = 33'd0;
      SECTOR_1: res = 33'd715827883;
      SECTOR_2: res = 33'd1431655766;
      SECTOR_3: res = 33'd2147483648;
      SECTOR_4: res = 33'd2863311531;
      SECTOR_5: res = 33'd3579139414;
      default:  res = 33'd0;
    endcase
    return res;
  endfunction

  // floor((s + 1) * 2^32 / 6): end of sector s in turn units
  function automatic logic [32:0] sector_end(input sector_e s);
    logic [32:0] res;
    case (s)
      SECTOR_0: res = 33'd715827882;
      SECTOR_1: res = 33'd1431655765;
      SECTOR_2: res = 33'd2147483648;
      SECTOR_3: res = 33'd2863311530;
      SECTOR_4: res = 33'd3579139413;
      SECTOR_5: res = 33'd4294967296;
      default:  res = 33'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/space_vector_pwm_modulator.sv =====
// Top level of the centered space vector PWM modulator: cell chains and glue.
// Uses svpwm_pkg, svpwm_cordic_cell, svpwm_sqrt_cell and svpwm_div_cell.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_we_i           cfg_wdata_i (supply limit)
//   in       in         valid_i / stall_o  uq_i, ud_i, elec_angle_i
//   out      out        valid_o / stall_i  duty_a_o, duty_b_o, duty_c_o, sector_index_o
//
// One transaction per cycle while stall_o is low; an accepted transaction passes
// through the vectoring and sine CORDIC chains, the 32-cell root chain and the
// 32-cell divider chain before valid_o. The whole chain moves together; a two-entry
// output queue absorbs stalls, and stall_o rises only while that queue is full.
// Reset clears all valid bits, the queue pointers and the supply limit (3072).
`default_nettype none

module space_vector_pwm_modulator
  import svpwm_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned DUTY_BITS     = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] uq_i,
  input  logic signed [15:0] ud_i,
  input  logic [15:0]        elec_angle_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [15:0]        duty_a_o,
  output logic [15:0]        duty_b_o,
  output logic [15:0]        duty_c_o,
  output logic [2:0]         sector_index_o
);

  localparam int unsigned VecSideW = $bits(vec_side_t);
  localparam int unsigned RootSideW = $bits(root_side_t);
  localparam int unsigned RootCells = 32;
  localparam int unsigned DivCells  = 32;
  localparam logic [31:0] AngMask =
    (ANGLE_BITS >= 16) ? 32'h0000_FFFF : ((32'd1 << ANGLE_BITS) - 32'd1);
  localparam int unsigned DutyPw = (DUTY_BITS + 32 > 46) ? DUTY_BITS + 32 : 46;
  localparam logic [DutyPw-1:0] DutyFull = (DutyPw'(1) << DUTY_BITS) - DutyPw'(1);
  localparam logic [DutyPw-1:0] DutyHalf = DutyPw'(1) << 29;
  localparam logic signed [42:0] OneWide = 43'sh4000_0000;

  logic adv;

  // ---------------------------------------------------------------------------
  // Configuration register
  logic [15:0] supply_lim_q;
  logic [15:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_lim_q <= 16'd3072;
    end else if (cfg_we_i) begin
      supply_lim_q <= cfg_wdata_i;
    end
  end

  // Treat a zero limit as one
  assign lim = (supply_lim_q == 16'd0) ? 16'd1 : supply_lim_q;

  // ---------------------------------------------------------------------------
  // Input stage: squared magnitude, half-turn pre-rotation, angle scaling
  logic signed [31:0] ud_sq, uq_sq;
  logic signed [16:0] ud_x, uq_x;
  logic               s0_valid_q;
  logic [31:0]        s0_sq_q, s0_ang_q;
  logic signed [16:0] s0_x_q, s0_y_q;
  logic               s0_neg_q, s0_zero_q;

  assign ud_sq = ud_i * ud_i;
  assign uq_sq = uq_i * uq_i;
  assign ud_x  = 17'(ud_i);
  assign uq_x  = 17'(uq_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_sq_q   <= 32'(ud_sq) + 32'(uq_sq);
      s0_ang_q  <= ({16'd0, elec_angle_i} & AngMask) << (32 - ANGLE_BITS);
      s0_x_q    <= ud_i[15] ? -ud_x : ud_x;
      s0_y_q    <= ud_i[15] ? -uq_x : uq_x;
      s0_neg_q  <= ud_i[15];
      s0_zero_q <= (ud_i == 16'sd0) && (uq_i == 16'sd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC chain: atan2(uq, ud)
  logic                       vv [CORDIC_STAGES+1];
  logic signed [VecXyW-1:0]   vx [CORDIC_STAGES+1];
  logic signed [VecXyW-1:0]   vy [CORDIC_STAGES+1];
  logic signed [CordicZw-1:0] vz [CORDIC_STAGES+1];
  logic [VecSideW-1:0]        vs [CORDIC_STAGES+1];
  vec_side_t                  vec_in, vec_out;

  assign vec_in = '{sq: s0_sq_q, ang: s0_ang_q, zero: s0_zero_q};
  assign vv[0]  = s0_valid_q;
  assign vx[0]  = {{3{s0_x_q[16]}}, s0_x_q, 20'd0};
  assign vy[0]  = {{3{s0_y_q[16]}}, s0_y_q, 20'd0};
  assign vz[0]  = s0_neg_q ? signed'({2'b00, TurnHalf}) : '0;
  assign vs[0]  = vec_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    svpwm_cordic_cell #(
      .STAGE (i),
      .MODE  (CORDIC_VECTOR),
      .XY_W  (VecXyW),
      .SIDE_W(VecSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(vv[i]),
      .x_i    (vx[i]),
      .y_i    (vy[i]),
      .z_i    (vz[i]),
      .side_i (vs[i]),
      .valid_o(vv[i+1]),
      .x_o    (vx[i+1]),
      .y_o    (vy[i+1]),
      .z_o    (vz[i+1]),
      .side_o (vs[i+1])
    );
  end

  assign vec_out = vec_side_t'(vs[CORDIC_STAGES]);

  // ---------------------------------------------------------------------------
  // Vector angle, sector and in-sector sine arguments
  logic        a_valid_q, b_valid_q, c_valid_q;
  logic [31:0] a_theta_q, a_sq_q, b_theta_q, b_sq_q, c_sq_q;
  logic [34:0] theta6;
  sector_e     b_sector_q;
  logic [32:0] arg_hi_w, arg_lo_w;
  root_side_t  c_side_q;

  assign theta6   = {1'b0, a_theta_q, 2'b00} + {2'b00, a_theta_q, 1'b0};
  assign arg_hi_w = sector_end(b_sector_q) - {1'b0, b_theta_q};
  assign arg_lo_w = {1'b0, b_theta_q} - sector_start(b_sector_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= vv[CORDIC_STAGES];
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_theta_q  <= vec_out.zero ? vec_out.ang
                                 : vec_out.ang + vz[CORDIC_STAGES][31:0];
      a_sq_q     <= vec_out.sq;
      b_theta_q  <= a_theta_q;
      b_sq_q     <= a_sq_q;
      b_sector_q <= sector_e'(theta6[34:32]);
      c_sq_q     <= b_sq_q;
      c_side_q   <= '{arg_hi: arg_hi_w[29:0], arg_lo: arg_lo_w[29:0], sector: b_sector_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Square root chain: floor(sqrt(sq * 2^32))
  logic                 rv [RootCells+1];
  logic [31:0]          rrad [RootCells+1];
  logic [35:0]          rrem [RootCells+1];
  logic [31:0]          rroot [RootCells+1];
  logic [RootSideW-1:0] rs [RootCells+1];

  assign rv[0]    = c_valid_q;
  assign rrad[0]  = c_sq_q;
  assign rrem[0]  = '0;
  assign rroot[0] = '0;
  assign rs[0]    = c_side_q;

  for (genvar i = 0; i < RootCells; i++) begin : g_root
    svpwm_sqrt_cell #(
      .SIDE_W(RootSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(rv[i]),
      .rad_i  (rrad[i]),
      .rem_i  (rrem[i]),
      .root_i (rroot[i]),
      .side_i (rs[i]),
      .valid_o(rv[i+1]),
      .rad_o  (rrad[i+1]),
      .rem_o  (rrem[i+1]),
      .root_o (rroot[i+1]),
      .side_o (rs[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Divider chain: magnitude / supply limit
  logic                 dv [DivCells+1];
  logic [31:0]          dnum [DivCells+1];
  logic [15:0]          drem [DivCells+1];
  logic [31:0]          dquo [DivCells+1];
  logic [RootSideW-1:0] ds [DivCells+1];

  assign dv[0]   = rv[RootCells];
  assign dnum[0] = rroot[RootCells];
  assign drem[0] = '0;
  assign dquo[0] = '0;
  assign ds[0]   = rs[RootCells];

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    svpwm_div_cell #(
      .SIDE_W(RootSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .lim_i  (lim),
      .valid_i(dv[i]),
      .num_i  (dnum[i]),
      .rem_i  (drem[i]),
      .quo_i  (dquo[i]),
      .side_i (ds[i]),
      .valid_o(dv[i+1]),
      .num_o  (dnum[i+1]),
      .rem_o  (drem[i+1]),
      .quo_o  (dquo[i+1]),
      .side_o (ds[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Saturate the ratio
  logic        r_valid_q;
  logic [24:0] r_ratio_q;
  root_side_t  div_side, r_side_q;

  assign div_side = root_side_t'(ds[DivCells]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (adv) begin
      r_valid_q <= dv[DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_ratio_q <= (dquo[DivCells] > 32'(RatioMax)) ? RatioMax : dquo[DivCells][24:0];
      r_side_q  <= div_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Two rotation CORDIC chains: sin(60deg - f) and sin(f)
  logic                       hv [CORDIC_STAGES+1];
  logic signed [RotXyW-1:0]   hx [CORDIC_STAGES+1];
  logic signed [RotXyW-1:0]   hy [CORDIC_STAGES+1];
  logic signed [CordicZw-1:0] hz [CORDIC_STAGES+1];
  logic [24:0]                hs [CORDIC_STAGES+1];
  logic                       lv [CORDIC_STAGES+1];
  logic signed [RotXyW-1:0]   lx [CORDIC_STAGES+1];
  logic signed [RotXyW-1:0]   ly [CORDIC_STAGES+1];
  logic signed [CordicZw-1:0] lz [CORDIC_STAGES+1];
  logic [2:0]                 ls [CORDIC_STAGES+1];

  assign hv[0] = r_valid_q;
  assign hx[0] = CordicK;
  assign hy[0] = '0;
  assign hz[0] = signed'({4'b0000, r_side_q.arg_hi});
  assign hs[0] = r_ratio_q;
  assign lv[0] = r_valid_q;
  assign lx[0] = CordicK;
  assign ly[0] = '0;
  assign lz[0] = signed'({4'b0000, r_side_q.arg_lo});
  assign ls[0] = r_side_q.sector;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    svpwm_cordic_cell #(
      .STAGE (i),
      .MODE  (CORDIC_ROTATE),
      .XY_W  (RotXyW),
      .SIDE_W(25)
    ) u_hi (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(hv[i]),
      .x_i    (hx[i]),
      .y_i    (hy[i]),
      .z_i    (hz[i]),
      .side_i (hs[i]),
      .valid_o(hv[i+1]),
      .x_o    (hx[i+1]),
      .y_o    (hy[i+1]),
      .z_o    (hz[i+1]),
      .side_o (hs[i+1])
    );
    svpwm_cordic_cell #(
      .STAGE (i),
      .MODE  (CORDIC_ROTATE),
      .XY_W  (RotXyW),
      .SIDE_W(3)
    ) u_lo (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(lv[i]),
      .x_i    (lx[i]),
      .y_i    (ly[i]),
      .z_i    (lz[i]),
      .side_i (ls[i]),
      .valid_o(lv[i+1]),
      .x_o    (lx[i+1]),
      .y_o    (ly[i+1]),
      .z_o    (lz[i+1]),
      .side_o (ls[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Active times: clamp sine, scale by sqrt3, then by the ratio
  function automatic logic [30:0] clamp_sin(input logic signed [RotXyW-1:0] y);
    logic [30:0] res;
    if (y[RotXyW-1]) begin
      res = '0;
    end else if (y > signed'(RotXyW'(OneQ30))) begin
      res = OneQ30;
    end else begin
      res = y[30:0];
    end
    return res;
  endfunction

  logic [61:0] p1_hi, p1_lo;
  logic        t_valid_q, u_valid_q;
  logic [30:0] t_hi_q, t_lo_q;
  logic [24:0] t_ratio_q;
  sector_e     t_sector_q, u_sector_q;
  logic [55:0] p2_hi, p2_lo;
  logic [39:0] u_hi_q, u_lo_q;

  assign p1_hi = 62'(clamp_sin(hy[CORDIC_STAGES])) * 62'(Sqrt3Q30);
  assign p1_lo = 62'(clamp_sin(ly[CORDIC_STAGES])) * 62'(Sqrt3Q30);
  assign p2_hi = 56'(t_hi_q) * 56'(t_ratio_q);
  assign p2_lo = 56'(t_lo_q) * 56'(t_ratio_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
      u_valid_q <= 1'b0;
    end else if (adv) begin
      t_valid_q <= hv[CORDIC_STAGES] & lv[CORDIC_STAGES];
      u_valid_q <= t_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_hi_q     <= p1_hi[60:30];
      t_lo_q     <= p1_lo[60:30];
      t_ratio_q  <= hs[CORDIC_STAGES];
      t_sector_q <= sector_e'(ls[CORDIC_STAGES]);
      u_hi_q     <= p2_hi[55:16];
      u_lo_q     <= p2_lo[55:16];
      u_sector_q <= t_sector_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase sums with centered zero time, clamped to [0, 1]
  function automatic logic [30:0] clamp_one(input logic signed [42:0] v);
    logic [30:0] res;
    if (v[42]) begin
      res = '0;
    end else if (v > OneWide) begin
      res = OneQ30;
    end else begin
      res = v[30:0];
    end
    return res;
  endfunction

  logic signed [42:0] t1s, t2s, half0, da, db, dc;
  logic               v_valid_q, w_valid_q;
  logic [30:0]        v_a_q, v_b_q, v_c_q;
  sector_e            v_sector_q;

  assign t1s   = signed'({3'b000, u_hi_q});
  assign t2s   = signed'({3'b000, u_lo_q});
  assign half0 = (OneWide - t1s - t2s) >>> 1;

  always_comb begin
    da = t1s + t2s + half0;
    db = half0;
    dc = t1s + half0;
    case (u_sector_q)
      SECTOR_0: begin
        da = t1s + t2s + half0;
        db = t2s + half0;
        dc = half0;
      end
      SECTOR_1: begin
        da = t1s + half0;
        db = t1s + t2s + half0;
        dc = half0;
      end
      SECTOR_2: begin
        da = half0;
        db = t1s + t2s + half0;
        dc = t2s + half0;
      end
      SECTOR_3: begin
        da = half0;
        db = t1s + half0;
        dc = t1s + t2s + half0;
      end
      SECTOR_4: begin
        da = t2s + half0;
        db = half0;
        dc = t1s + t2s + half0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Scale to duty width with rounding
  logic [DutyPw-1:0] m_a, m_b, m_c;
  result_t           w_res_q;

  assign m_a = DutyPw'(v_a_q) * DutyFull + DutyHalf;
  assign m_b = DutyPw'(v_b_q) * DutyFull + DutyHalf;
  assign m_c = DutyPw'(v_c_q) * DutyFull + DutyHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
    end else if (adv) begin
      v_valid_q <= u_valid_q;
      w_valid_q <= v_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_a_q      <= clamp_one(da);
      v_b_q      <= clamp_one(db);
      v_c_q      <= clamp_one(dc);
      v_sector_q <= u_sector_q;
      w_res_q    <= '{duty_a: m_a[30 +: 16], duty_b: m_b[30 +: 16],
                      duty_c: m_c[30 +: 16], sector: v_sector_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output queue; the chain advances while it has room
  result_t    fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  result_t    head;

  assign adv     = (count_q != 2'd2);
  assign stall_o = ~adv;
  assign push    = adv & w_valid_q;
  assign pop     = valid_o & ~stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= w_res_q;
    end
  end

  assign head           = fifo_q[rd_ptr_q];
  assign valid_o        = (count_q != 2'd0);
  assign duty_a_o       = head.duty_a;
  assign duty_b_o       = head.duty_b;
  assign duty_c_o       = head.duty_c;
  assign sector_index_o = head.sector;

endmodule

`default_nettype wire

// ===== rtl/svpwm_cordic_cell.sv =====
// One CORDIC micro-rotation cell, vectoring or rotation mode, with side payload.
// Depends on svpwm_pkg for the angle table and mode type.
`default_nettype none

module svpwm_cordic_cell
  import svpwm_pkg::*;
#(
  parameter int unsigned  STAGE  = 0,
  parameter cordic_mode_e MODE   = CORDIC_ROTATE,
  parameter int unsigned  XY_W   = 34,
  parameter int unsigned  SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [XY_W-1:0]     x_i,
  input  logic signed [XY_W-1:0]     y_i,
  input  logic signed [CordicZw-1:0] z_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic signed [XY_W-1:0]     x_o,
  output logic signed [XY_W-1:0]     y_o,
  output logic signed [CordicZw-1:0] z_o,
  output logic [SIDE_W-1:0]          side_o
);

  logic signed [XY_W-1:0]     xs, ys, x_d, y_d;
  logic signed [CordicZw-1:0] step, z_d;
  logic                       pos;

  assign xs   = x_i >>> STAGE;
  assign ys   = y_i >>> STAGE;
  assign step = signed'(CordicZw'(atan_turn(STAGE)));

  // Pick rotation direction and rotate
  always_comb begin
    if (MODE == CORDIC_VECTOR) begin
      pos = y_i[XY_W-1] || (y_i == '0);
    end else begin
      pos = ~z_i[CordicZw-1];
    end
    if (pos) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - step;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svpwm_sqrt_cell.sv =====
// One digit-pair step of a restoring square root on a 64-bit radicand.
// Upper radicand half enters as rad_i; the low half is implicitly zero.
`default_nettype none

module svpwm_sqrt_cell
  import svpwm_pkg::*;
#(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       rad_i,
  input  logic [35:0]       rem_i,
  input  logic [31:0]       root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       rad_o,
  output logic [35:0]       rem_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [35:0] rem_sh, trial, rem_d;
  logic        ge;

  // Bring down two radicand bits and try 4*root+1
  assign rem_sh = {rem_i[33:0], rad_i[31:30]};
  assign trial  = {2'b00, root_i, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign rem_d  = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[29:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= {root_i[30:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svpwm_div_cell.sv =====
// One quotient bit of a restoring 32 by 16 bit unsigned division.
// Divisor comes from the configuration register and is never zero.
`default_nettype none

module svpwm_div_cell
  import svpwm_pkg::*;
#(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [15:0]       lim_i,
  input  logic              valid_i,
  input  logic [31:0]       num_i,
  input  logic [15:0]       rem_i,
  input  logic [31:0]       quo_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       num_o,
  output logic [15:0]       rem_o,
  output logic [31:0]       quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [16:0] rem_sh, diff;
  logic        ge;

  // Shift in next dividend bit, subtract divisor when it fits
  assign rem_sh = {rem_i, num_i[31]};
  assign ge     = (rem_sh >= {1'b0, lim_i});
  assign diff   = rem_sh - {1'b0, lim_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= {num_i[30:0], 1'b0};
      rem_o  <= ge ? diff[15:0] : rem_sh[15:0];
      quo_o  <= {quo_i[30:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svpwm_port_checker.sv =====
// Port-level checker for the space vector PWM modulator, bound to the top level.
// Uses the assertion macros of space_vector_pwm_modulator_defines.svh.
`default_nettype none
`include "space_vector_pwm_modulator_defines.svh"

module svpwm_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [15:0] duty_a_o,
  input logic [2:0]  sector_index_o
);

  // Sector code stays inside the six sectors
  `SVPWM_ASSERT_NOW(a_sector_range, valid_o, sector_index_o <= 3'd5)

  // Input backpressure only while results are queued
  `SVPWM_ASSERT_NOW(a_stall_needs_result, stall_o, valid_o)

  // A stalled result holds
  `SVPWM_ASSERT_NEXT(a_result_holds, valid_o && stall_i, valid_o && $stable(duty_a_o) && $stable(sector_index_o))

endmodule

bind space_vector_pwm_modulator svpwm_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .duty_a_o      (duty_a_o),
  .sector_index_o(sector_index_o)
);

`default_nettype wire

// ===== tb/space_vector_pwm_modulator_tb.sv =====
// Self-checking testbench of the centered space vector PWM modulator.
// Depends on svpwm_pkg and space_vector_pwm_modulator; a built-in predictor or a fixed row checks every duty.
`default_nettype none

module space_vector_pwm_modulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svpwm_pkg::*;

  localparam int unsigned Stages   = 16;
  localparam int unsigned Latency  = 2 * Stages + 73;
  localparam longint      CycleCap = 400000;
  localparam longint      Q30      = 64'sd1 << 30;

  typedef struct {
    logic signed [15:0] uq;
    logic signed [15:0] ud;
    logic [15:0]        ang;
    bit                 fixed;
    result_t            res;
  } drive_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [15:0] uq_i = '0;
  logic signed [15:0] ud_i = '0;
  logic [15:0] elec_angle_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [15:0] duty_a_o, duty_b_o, duty_c_o;
  logic [2:0] sector_index_o;

  space_vector_pwm_modulator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] volt_limit;
  result_t     duty_queue[$];
  int unsigned mismatches = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;
  bit          feed_done = 1'b0;
  int unsigned sent = 0;
  int unsigned rx_gap = 0;

  // Floor shift of a signed value
  function automatic longint shr_floor(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_step(int unsigned i);
    logic [31:0] t[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                           32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                           32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                           32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    return t[i];
  endfunction

  function automatic logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] z = 0;
    longint xs, ys;
    if (x == 0 && y == 0) return 0;
    x = x * (64'sd1 << 20);
    y = y * (64'sd1 << 20);
    if (x < 0) begin
      x = -x;
      y = -y;
      z = TurnHalf;
    end
    for (int unsigned i = 0; i < Stages; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint sine_q30(longint a);
    longint x = 652032875, y = 0, z = a, xs, ys;
    for (int unsigned i = 0; i < Stages; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_step(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_step(i));
      end
    end
    if (y < 0) y = 0;
    if (y > Q30) y = Q30;
    return y;
  endfunction

  function automatic longint dwell(longint s, longint unsigned ratio);
    longint unsigned t = (longint'(s) * 64'd1859775393) >> 30;
    return longint'((t * ratio) >> 16);
  endfunction

  function automatic logic [15:0] scale_duty(longint v);
    if (v < 0) v = 0;
    if (v > Q30) v = Q30;
    return 16'((longint'(v) * 65535 + (64'sd1 << 29)) >>> 30);
  endfunction

  // Predict one modulator result from the command vector and current limit
  function automatic result_t predict_duties(logic signed [15:0] uq, logic signed [15:0] ud,
                                             logic [15:0] ang);
    result_t r;
    longint unsigned lim = (volt_limit == 0) ? 1 : volt_limit;
    longint unsigned sq = longint'(ud) * ud + longint'(uq) * uq;
    longint unsigned ratio = root64(sq << 32) / lim;
    longint unsigned prod, frac;
    logic [31:0] theta;
    longint t1, t2, h, da, db, dc;
    int sec;
    if (ratio > 64'd16777216) ratio = 64'd16777216;
    theta = {ang, 16'h0} + vector_angle(ud, uq);
    prod = longint'(theta) * 6;
    sec = int'(prod >> 32);
    frac = prod & 64'hFFFF_FFFF;
    t1 = dwell(sine_q30(longint'(((64'd1 << 32) - frac) / 6)), ratio);
    t2 = dwell(sine_q30(longint'(frac / 6)), ratio);
    h = (Q30 - t1 - t2) >>> 1;
    case (sec)
      0: begin da = t1 + t2 + h; db = t2 + h; dc = h; end
      1: begin da = t1 + h; db = t1 + t2 + h; dc = h; end
      2: begin da = h; db = t1 + t2 + h; dc = t2 + h; end
      3: begin da = h; db = t1 + h; dc = t1 + t2 + h; end
      4: begin da = t2 + h; db = h; dc = t1 + t2 + h; end
      default: begin da = t1 + t2 + h; db = h; dc = t1 + h; end
    endcase
    r.duty_a = scale_duty(da);
    r.duty_b = scale_duty(db);
    r.duty_c = scale_duty(dc);
    r.sector = sector_e'(sec);
    return r;
  endfunction

  // Directed rows; the zero vector gives one-half duties and the angle's sector
  drive_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'h0000, 1'b1, '{16'h8000, 16'h8000, 16'h8000, SECTOR_0}},
    '{16'sd0, 16'sd0, 16'h4000, 1'b1, '{16'h8000, 16'h8000, 16'h8000, SECTOR_1}},
    '{16'sd0, 16'sd0, 16'h8000, 1'b1, '{16'h8000, 16'h8000, 16'h8000, SECTOR_3}},
    '{16'sd0, 16'sd0, 16'hFFFF, 1'b1, '{16'h8000, 16'h8000, 16'h8000, SECTOR_5}},
    '{16'sd1000, 16'sd0, 16'h0000, 1'b0, '0},
    '{16'sd0, 16'sd1000, 16'h2AAA, 1'b0, '0},
    '{-16'sd1000, 16'sd0, 16'h5555, 1'b0, '0},
    '{16'sd0, -16'sd1000, 16'hAAAA, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 16'h1234, 1'b0, '0},
    '{-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0, '0},
    '{-16'sd32768, 16'sd32767, 16'h8000, 1'b0, '0},
    '{16'sd32767, -16'sd32768, 16'h0001, 1'b0, '0},
    '{16'sd1, 16'sd0, 16'hC000, 1'b0, '0},
    '{16'sd0, -16'sd1, 16'h7FFF, 1'b0, '0},
    '{16'sd1500, 16'sd1500, 16'hD555, 1'b0, '0},
    '{16'sd3072, 16'sd0, 16'h3000, 1'b0, '0}
  };

  task automatic cycle_wait(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    volt_limit = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one transaction and hold it until accepted; idle first if a gap is drawn
  task automatic send_vector(logic signed [15:0] uq, logic signed [15:0] ud, logic [15:0] ang,
                             bit fixed, result_t res);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      valid_i <= 1'b0;
      cycle_wait(gap);
    end
    valid_i <= 1'b1;
    uq_i <= uq;
    ud_i <= ud;
    elec_angle_i <= ang;
    do @(posedge clk_i); while (stall_o);
    duty_queue.push_back(fixed ? res : predict_duties(uq, ud, ang));
    sent++;
  endtask

  // Drop valid and wait until every transaction has come out
  task automatic drain;
    valid_i <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk_i);
    cycle_wait(4);
  endtask

  task automatic random_batch(int unsigned n, bit narrow);
    logic signed [15:0] q, d;
    for (int unsigned i = 0; i < n; i++) begin
      q = narrow ? 16'($signed($urandom_range(0, 8191)) - 4096) : 16'($urandom);
      d = narrow ? 16'($signed($urandom_range(0, 8191)) - 4096) : 16'($urandom);
      if ($urandom_range(0, 19) == 0) begin
        q = 0;
        d = 0;
      end
      send_vector(q, d, 16'($urandom), 1'b0, '0);
    end
  endtask

  // Stimulus: directed rows, then random phases over several limits
  initial begin
    logic [15:0] limits[5] = '{16'd0, 16'd1, 16'd65535, 16'd3072, 16'd40000};
    volt_limit = 16'd3072;
    cycle_wait(8);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k])
      send_vector(directed[k].uq, directed[k].ud, directed[k].ang, directed[k].fixed,
                  directed[k].res);
    random_batch(100, 1'b0);
    foreach (limits[k]) begin
      drain();
      write_limit(limits[k]);
      random_batch(190, 1'b0);
      random_batch(190, 1'b1);
    end
    drain();
    write_limit(16'($urandom_range(1, 65535)));
    random_batch(200, 1'b1);
    drain();
    cycle_wait(Latency);
    feed_done = 1'b1;
  end

  // Long receiver hold-off in the middle of a long batch
  initial begin
    wait (sent >= 600);
    hold_off = 1'b1;
    cycle_wait(300);
    hold_off = 1'b0;
  end

  // Receiver: draw a new random stall wait after every transaction taken
  always @(posedge clk_i) begin
    int unsigned n;
    n = rx_gap;
    if (rst_ni && valid_o && !stall_i) n = $urandom_range(0, 3);
    if (hold_off) begin
      stall_i <= 1'b1;
    end else if (n != 0) begin
      stall_i <= 1'b1;
      n--;
    end else begin
      stall_i <= 1'b0;
    end
    rx_gap = n;
  end

  // Compare each transaction with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    cycles <= cycles + 1;
    if (rst_ni && valid_o && !stall_i) begin
      if (duty_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
      end else begin
        want = duty_queue.pop_front();
        if (duty_a_o !== want.duty_a || duty_b_o !== want.duty_b ||
            duty_c_o !== want.duty_c || sector_index_o !== want.sector) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %h %h %h s%0d got %h %h %h s%0d", want.duty_a,
                     want.duty_b, want.duty_c, want.sector, duty_a_o, duty_b_o, duty_c_o,
                     sector_index_o);
        end
      end
    end
  end

  // End of run or timeout
  initial begin
    while (!feed_done && cycles < CycleCap) @(posedge clk_i);
    if (feed_done && mismatches == 0 && duty_queue.size() == 0) begin
      $display("[space_vector_pwm_modulator] OK");
    end else begin
      $display("[space_vector_pwm_modulator] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/svpwm_pkg.sv
rtl/svpwm_cordic_cell.sv
rtl/svpwm_sqrt_cell.sv
rtl/svpwm_div_cell.sv
rtl/space_vector_pwm_modulator.sv
rtl/svpwm_port_checker.sv
tb/space_vector_pwm_modulator_tb.sv
